// ===== src/lqbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lqbd_pkg
// Shared types, format codes and layout helpers of the block dequantizer.
// ----------------------------------------------------------------------------
package lqbd_pkg;

  localparam logic [2:0] FMT_Q4_0 = 3'd0;
  localparam logic [2:0] FMT_Q4_1 = 3'd1;
  localparam logic [2:0] FMT_Q5_0 = 3'd2;
  localparam logic [2:0] FMT_Q5_1 = 3'd3;
  localparam logic [2:0] FMT_Q8_0 = 3'd4;

  localparam int BLOCK_ELEMS = 32;
  localparam int QBUF_DEPTH  = 32;

  typedef struct packed {
    logic       wr;
    logic [5:0] wr_addr;
    logic       issue;
    logic [4:0] elem;
    logic [2:0] fmt;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_stat_t;

  // Total bytes of one block; zero marks a reserved format code.
  function automatic logic [5:0] block_bytes(input logic [2:0] fmt);
    logic [5:0] n;
    unique case (fmt)
      FMT_Q4_0: n = 6'd18;
      FMT_Q4_1: n = 6'd20;
      FMT_Q5_0: n = 6'd22;
      FMT_Q5_1: n = 6'd24;
      FMT_Q8_0: n = 6'd34;
      default:  n = 6'd0;
    endcase
    return n;
  endfunction

  // Bytes of scale, minimum and high-bit word ahead of the quant bytes.
  function automatic logic [5:0] hdr_bytes(input logic [2:0] fmt);
    logic [5:0] n;
    unique case (fmt)
      FMT_Q4_1: n = 6'd4;
      FMT_Q5_0: n = 6'd6;
      FMT_Q5_1: n = 6'd8;
      default:  n = 6'd2;
    endcase
    return n;
  endfunction

endpackage

// ===== src/lqbd_ram.sv =====
// ----------------------------------------------------------------------------
// lqbd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lqbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lqbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lqbd_ctrl
// Controller: format register, byte counter and element sequencer.
// ----------------------------------------------------------------------------
module lqbd_ctrl
  import lqbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      cfg_wr,
  input  logic [2:0] cfg_fmt,
  input  dp_stat_t  stat,
  output logic      busy,
  output logic [2:0] fmt,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {ST_COLLECT, ST_EMIT, ST_DRAIN} state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [4:0] elem_r, elem_nxt;
  logic [2:0] fmt_r, fmt_nxt;
  logic       busy_r, busy_nxt;
  logic [5:0] size;
  logic       accept;

  assign size   = block_bytes(fmt_r);
  assign accept = start && !busy_r && (size != 6'd0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    elem_nxt  = elem_r;
    fmt_nxt   = fmt_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (cfg_wr) begin
          fmt_nxt = cfg_fmt;
          cnt_nxt = 6'd0;
        end else if (accept) begin
          if (cnt_r == size - 6'd1) begin
            cnt_nxt   = 6'd0;
            elem_nxt  = 5'd0;
            state_nxt = ST_EMIT;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      ST_EMIT: begin
        elem_nxt = elem_r + 5'd1;
        if (elem_r == 5'(BLOCK_ELEMS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
    busy_nxt = (state_nxt != ST_COLLECT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cnt_r   <= 6'd0;
      elem_r  <= 5'd0;
      fmt_r   <= FMT_Q4_0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      elem_r  <= elem_nxt;
      fmt_r   <= fmt_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy        = busy_r;
  assign fmt         = fmt_r;
  assign cmd.wr      = accept;
  assign cmd.wr_addr = cnt_r;
  assign cmd.issue   = (state_r == ST_EMIT);
  assign cmd.elem    = elem_r;
  assign cmd.fmt     = fmt_r;

endmodule

// ===== src/lqbd_dp.sv =====
// ----------------------------------------------------------------------------
// lqbd_dp
// Datapath: block header registers, quant byte RAM and the pipeline that
// turns one element per cycle into its fp32 value.
// ----------------------------------------------------------------------------
module lqbd_dp
  import lqbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  input  logic [7:0]  data_byte,
  output dp_stat_t    stat,
  output logic        out_valid,
  output logic [31:0] out_value_bits,
  output logic [4:0]  out_element_index,
  output logic        out_block_end
);

  localparam int AW = $clog2(QBUF_DEPTH);

  typedef struct packed {
    logic [4:0]  k;
    logic        spec;
    logic [31:0] spec_bits;
    logic        zsign;
  } tag_t;

  // Header bytes: scale, minimum and high-bit word, by position in the block.
  logic [7:0] hdr_r [8];
  logic [5:0] hlen;
  logic       hdr_wr;

  assign hlen   = hdr_bytes(cmd.fmt);
  assign hdr_wr = cmd.wr && (cmd.wr_addr < hlen);

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[cmd.wr_addr[2:0]] <= data_byte;
    end
  end

  logic [5:0]    qwaddr;
  logic [AW-1:0] qraddr;
  logic [7:0]    qrdata;

  assign qwaddr = cmd.wr_addr - hlen;
  assign qraddr = (cmd.fmt == FMT_Q8_0) ? cmd.elem : {1'b0, cmd.elem[3:0]};

  lqbd_ram #(.WIDTH(8), .DEPTH(QBUF_DEPTH)) u_qbuf (
    .clk   (clk),
    .we    (cmd.wr && !hdr_wr),
    .waddr (qwaddr[AW-1:0]),
    .wdata (data_byte),
    .raddr (qraddr),
    .rdata (qrdata)
  );

  // Per-block constants decoded from the header.
  logic [15:0] d_h, m_h;
  logic [31:0] qh;
  logic        has_min;
  logic [10:0] d_sig, m_sig;
  logic [4:0]  d_sh, m_sh;
  logic        d_nan, d_inf, d_zero, m_nan, m_inf, m_zero;
  logic [31:0] d_qnan, m_qnan;

  assign d_h     = {hdr_r[1], hdr_r[0]};
  assign m_h     = {hdr_r[3], hdr_r[2]};
  assign qh      = (cmd.fmt == FMT_Q5_0) ? {hdr_r[5], hdr_r[4], hdr_r[3], hdr_r[2]}
                                         : {hdr_r[7], hdr_r[6], hdr_r[5], hdr_r[4]};
  assign has_min = (cmd.fmt == FMT_Q4_1) || (cmd.fmt == FMT_Q5_1);

  // In units of 2^-24 an fp16 value is its significand shifted by exponent-1.
  assign d_sig  = (d_h[14:10] == 5'd0) ? {1'b0, d_h[9:0]} : {1'b1, d_h[9:0]};
  assign m_sig  = (m_h[14:10] == 5'd0) ? {1'b0, m_h[9:0]} : {1'b1, m_h[9:0]};
  assign d_sh   = (d_h[14:10] == 5'd0) ? 5'd0 : d_h[14:10] - 5'd1;
  assign m_sh   = (m_h[14:10] == 5'd0) ? 5'd0 : m_h[14:10] - 5'd1;
  assign d_nan  = (d_h[14:10] == 5'h1F) && (d_h[9:0] != 10'd0);
  assign d_inf  = (d_h[14:10] == 5'h1F) && (d_h[9:0] == 10'd0);
  assign d_zero = (d_h[14:0] == 15'd0);
  assign m_nan  = (m_h[14:10] == 5'h1F) && (m_h[9:0] != 10'd0);
  assign m_inf  = (m_h[14:10] == 5'h1F) && (m_h[9:0] == 10'd0);
  assign m_zero = (m_h[14:0] == 15'd0);
  assign d_qnan = {d_h[15], 8'hFF, 1'b1, d_h[8:0], 13'd0};
  assign m_qnan = {m_h[15], 8'hFF, 1'b1, m_h[8:0], 13'd0};

  // Stage 1: quant byte arrives from the RAM.
  logic       v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [4:0] k1_r, k2_r;
  logic       qb1_r;

  always_ff @(posedge clk) begin
    k1_r  <= cmd.elem;
    qb1_r <= qh[cmd.elem];
  end

  logic [3:0] nib;
  logic [8:0] q;
  logic [8:0] qneg_full;

  assign nib = k1_r[4] ? qrdata[7:4] : qrdata[3:0];

  always_comb begin
    case (cmd.fmt)
      FMT_Q4_0: q = {5'd0, nib} - 9'd8;
      FMT_Q4_1: q = {5'd0, nib};
      FMT_Q5_0: q = {4'd0, qb1_r, nib} - 9'd16;
      FMT_Q5_1: q = {4'd0, qb1_r, nib};
      default:  q = {qrdata[7], qrdata};
    endcase
  end

  assign qneg_full = 9'd0 - q;

  logic [7:0] qabs2_r;
  logic       qneg2_r;

  always_ff @(posedge clk) begin
    qabs2_r <= q[8] ? qneg_full[7:0] : q[7:0];
    qneg2_r <= q[8];
    k2_r    <= k1_r;
  end

  // Stage 2: integer multiply by the scale significand; IEEE special cases.
  logic        psign, qzero, p_nan, p_inf;
  logic [31:0] p_nan_bits;
  tag_t        tag2;

  assign psign      = qneg2_r ^ d_h[15];
  assign qzero      = (qabs2_r == 8'd0);
  assign p_nan      = d_nan || (d_inf && qzero);
  assign p_inf      = d_inf && !qzero;
  assign p_nan_bits = d_nan ? d_qnan : 32'hFFC0_0000;

  always_comb begin
    tag2.k         = k2_r;
    tag2.spec      = 1'b1;
    tag2.spec_bits = 32'd0;
    if (p_nan) begin
      tag2.spec_bits = p_nan_bits;
    end else if (has_min && m_nan) begin
      tag2.spec_bits = m_qnan;
    end else if (has_min && p_inf && m_inf && (psign != m_h[15])) begin
      tag2.spec_bits = 32'hFFC0_0000;
    end else if (p_inf) begin
      tag2.spec_bits = {psign, 31'h7F80_0000};
    end else if (has_min && m_inf) begin
      tag2.spec_bits = {m_h[15], 31'h7F80_0000};
    end else begin
      tag2.spec = 1'b0;
    end
    // Exact zero: with a minimum, -0 only when both addends are negative zeros; without one, the product's sign.
    tag2.zsign = has_min ? ((qzero || d_zero) && m_zero && psign && m_h[15]) : psign;
  end

  logic [18:0] prod3_r;
  logic        psign3_r;
  tag_t        tag3_r, tag4_r, tag5_r, tag6_r, tag7_r;

  always_ff @(posedge clk) begin
    prod3_r  <= 19'(qabs2_r) * 19'(d_sig);
    psign3_r <= psign;
    tag3_r   <= tag2;
  end

  // Stage 3: exact fixed-point sum of product and minimum.
  logic [47:0] p_fix;
  logic [39:0] m_fix;
  logic [49:0] p_s, m_s;
  logic [49:0] sum4_r;

  assign p_fix = 48'(prod3_r) << d_sh;
  assign m_fix = 40'(m_sig) << m_sh;
  assign p_s   = psign3_r ? 50'd0 - {2'd0, p_fix} : {2'd0, p_fix};
  assign m_s   = !has_min ? 50'd0 : (m_h[15] ? 50'd0 - {10'd0, m_fix} : {10'd0, m_fix});

  always_ff @(posedge clk) begin
    sum4_r <= p_s + m_s;
    tag4_r <= tag3_r;
  end

  // Stage 4: magnitude and sign.
  logic [48:0] mag5_r;
  logic        sgn5_r, sgn6_r, sgn7_r, sgn8_r;
  logic [49:0] sum_neg;

  assign sum_neg = 50'd0 - sum4_r;

  always_ff @(posedge clk) begin
    mag5_r <= sum4_r[49] ? sum_neg[48:0] : sum4_r[48:0];
    sgn5_r <= sum4_r[49];
    tag5_r <= tag4_r;
  end

  // Stage 5: leading-one position inside each byte of the magnitude.
  logic [55:0] mag56;
  logic [6:0]  gnz;
  logic [2:0]  gpos [7];

  assign mag56 = {7'd0, mag5_r};

  always_comb begin
    for (int g = 0; g < 7; g++) begin
      gnz[g]  = |mag56[8*g +: 8];
      gpos[g] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (mag56[8*g + i]) begin
          gpos[g] = 3'(i);
        end
      end
    end
  end

  logic [55:0] mag6_r, mag7_r;
  logic [6:0]  gnz6_r;
  logic [2:0]  gpos6_r [7];

  always_ff @(posedge clk) begin
    mag6_r  <= mag56;
    gnz6_r  <= gnz;
    gpos6_r <= gpos;
    sgn6_r  <= sgn5_r;
    tag6_r  <= tag5_r;
  end

  // Stage 6: pick the highest nonzero byte.
  logic [5:0] lead;

  always_comb begin
    lead = 6'd0;
    for (int g = 0; g < 7; g++) begin
      if (gnz6_r[g]) begin
        lead = {3'(g), gpos6_r[g]};
      end
    end
  end

  logic [5:0] lead7_r;
  logic       nz7_r, nz8_r;

  always_ff @(posedge clk) begin
    mag7_r  <= mag6_r;
    lead7_r <= lead;
    nz7_r   <= |gnz6_r;
    sgn7_r  <= sgn6_r;
    tag7_r  <= tag6_r;
  end

  // Stage 7: normalize so the leading one sits at the top bit.
  logic [55:0] norm8_r;
  logic [7:0]  exp8_r;
  tag_t        tag8_r;

  always_ff @(posedge clk) begin
    norm8_r <= mag7_r << (6'd55 - lead7_r);
    exp8_r  <= 8'(lead7_r) + 8'd103;
    nz8_r   <= nz7_r;
    sgn8_r  <= sgn7_r;
    tag8_r  <= tag7_r;
  end

  // Stage 8: round to nearest even and pack.
  logic        rup;
  logic [24:0] sig25;
  logic [7:0]  exp_f;
  logic [22:0] mant_f;
  logic [31:0] value;

  assign rup    = norm8_r[31] && ((|norm8_r[30:0]) || norm8_r[32]);
  assign sig25  = {1'b0, norm8_r[55:32]} + 25'(rup);
  assign exp_f  = sig25[24] ? exp8_r + 8'd1 : exp8_r;
  assign mant_f = sig25[24] ? sig25[23:1] : sig25[22:0];

  always_comb begin
    if (tag8_r.spec) begin
      value = tag8_r.spec_bits;
    end else if (!nz8_r) begin
      value = {tag8_r.zsign, 31'd0};
    end else begin
      value = {sgn8_r, exp_f, mant_f};
    end
  end

  logic        ov_r;
  logic [31:0] ovalue_r;
  logic [4:0]  oidx_r;

  always_ff @(posedge clk) begin
    ovalue_r <= value;
    oidx_r   <= tag8_r.k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      ov_r <= v8_r;
    end
  end

  assign stat.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r | v6_r | v7_r | v8_r | ov_r;

  assign out_valid         = ov_r;
  assign out_value_bits    = ovalue_r;
  assign out_element_index = oidx_r;
  assign out_block_end     = (oidx_r == 5'(BLOCK_ELEMS - 1));

endmodule

// ===== src/legacy_quant_block_dequantizer.sv =====
// ----------------------------------------------------------------------------
// legacy_quant_block_dequantizer
// Q4_0/Q4_1/Q5_0/Q5_1/Q8_0 block stream to fp32 element dequantizer.
// ----------------------------------------------------------------------------
// Bytes of the quantized stream enter on in_data_byte; a byte is taken at a
// clock edge where start is high and busy is low. The format register (APB,
// byte address 0) selects the block layout; writing it while busy is low
// restarts the block; a write while busy is high is ignored. Reserved
// format codes make the block drop incoming bytes. One byte is taken per
// cycle while start is high and a block is being collected. After the
// last byte of a block, busy rises and the 32 elements go through a
// nine-stage pipeline and leave one result every cycle with out_valid
// high, ending with out_block_end. Busy falls when the pipeline has
// drained. Results are shown for one cycle each; the receiver cannot
// stall them. Reset clears the format to Q4_0 and the byte count; the
// buffered block contents are not cleared and need no clearing.
// ----------------------------------------------------------------------------
module legacy_quant_block_dequantizer
  import lqbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [31:0] out_value_bits,
  output logic [4:0]  out_element_index,
  output logic        out_block_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [2:0] fmt;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {29'd0, fmt};

  lqbd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cfg_wr  (cfg_wr),
    .cfg_fmt (pwdata[2:0]),
    .stat    (stat),
    .busy    (busy),
    .fmt     (fmt),
    .cmd     (cmd)
  );

  lqbd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .data_byte         (in_data_byte),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_value_bits    (out_value_bits),
    .out_element_index (out_element_index),
    .out_block_end     (out_block_end)
  );

  // A result never appears while new bytes can be taken.
  a_out_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside of a busy period");

  // Elements of a block come on consecutive cycles in order.
  a_elem_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_block_end |=>
      out_valid && (out_element_index == 5'($past(out_element_index) + 5'd1)))
    else $error("element sequence broken");

  // The last element of a block is followed by a gap.
  a_block_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |=> !out_valid)
    else $error("result after block end");

endmodule
